// File: design/wgm_pkg.sv
// Package for the wildcard glob matcher.
// Holds opcodes, wildcard byte constants and the structs shared by the cells,
// the output buffer, the top level and the checker. Depends on nothing.
`timescale 1ns / 1ps

package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 32;

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } opcode_e;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic load;     // write the byte into the cell whose index equals the length
    logic consume;  // advance the prefix bits by one text byte
    logic restart;  // clear the prefix bits
  } cell_ctrl_t;

  // One result item.
  typedef struct packed {
    logic overflow;
    logic matched;
  } result_t;

endpackage

// File: design/wgm_cell.sv
// One cell of the matcher row: one pattern byte and one prefix bit.
// Uses wgm_pkg; instantiated by wildcard_glob_matcher_unit.
`timescale 1ns / 1ps

module wgm_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wgm_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          char_i,
  input  logic [LEN_W-1:0]    len_i,
  input  logic                closed_prev_i,
  output logic                closed_o,
  output logic                match_o
);
  import wgm_pkg::*;

  logic [7:0] pat_q;
  logic       act_q, act_d;
  logic       used, star, hit, nxt;

  // The cell takes part only while its index lies inside the pattern.
  assign used     = LEN_W'(IDX) < len_i;
  assign star     = used && (pat_q == STAR_BYTE);
  assign hit      = used && ((pat_q == QMARK_BYTE) || (pat_q == char_i));
  // Star closure ripples from the left neighbor.
  assign closed_o = act_q | (closed_prev_i & star);
  assign nxt      = (closed_prev_i & hit) | (star & closed_o);
  assign match_o  = closed_o && (len_i == LEN_W'(IDX + 1));

  always_comb begin
    act_d = act_q;
    if (ctrl_i.restart) begin
      act_d = 1'b0;
    end else if (ctrl_i.consume) begin
      act_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && (len_i == LEN_W'(IDX))) begin
      pat_q <= char_i;
    end
  end

endmodule

// File: design/wgm_out_buf.sv
// Two-entry output buffer (output register plus skid stage) for results.
// Uses wgm_pkg; instantiated by wildcard_glob_matcher_unit.
`timescale 1ns / 1ps

module wgm_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wgm_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output wgm_pkg::result_t data_o
);
  import wgm_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = out_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// File: design/wildcard_glob_matcher_unit.sv
// Top level of the wildcard glob matcher: decoder, row of matcher cells and
// output buffer. Depends on wgm_pkg, wgm_cell and wgm_out_buf.
//
// Usage: every input transfer carries an opcode in s_axis_tuser_i and a byte
// in s_axis_tdata_i. Clear empties the pattern and the overflow flag, append
// adds one pattern byte ('*' matches any run, '?' any one byte), a text byte
// advances the match, and end of text produces one result transfer on the
// master side: bit 0 says whether the whole text matched the whole pattern,
// bit 1 says whether pattern bytes were dropped because the store was full.
// Any append or clear, and every end of text, restarts text matching.
// Throughput is one input transfer per cycle while s_axis_tready_o is high;
// the result of an end of text is offered on m_axis in the cycle after its
// transfer when the output register is free, otherwise it waits in the skid
// stage until the result ahead of it is taken. Each cell holds one pattern
// byte and one prefix bit; the star closure ripples combinationally along
// the row of MAX_PATTERN cells, and that chain sets the clock period.
// After reset the pattern is empty, the overflow flag is clear and no result
// is pending. Results wait in a two-entry buffer; when the receiver stalls
// and both entries are full, s_axis_tready_o drops, and it rises again in the
// cycle after the receiver takes a result.
`timescale 1ns / 1ps

module wildcard_glob_matcher_unit #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_byte
  input  logic [1:0] s_axis_tuser_i,   // [1:0] opcode
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import wgm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]     len_q, len_d;
  logic                 ovf_q, ovf_d;
  logic                 a0_q, a0_d;       // empty-prefix bit
  logic                 accept;
  opcode_e              opcode;
  cell_ctrl_t           ctrl;
  logic                 emit;
  logic [MAX_PATTERN:0] closed;
  logic [MAX_PATTERN-1:0] match_vec;
  result_t              res, out_res;
  logic                 buf_ready;

  assign accept          = s_axis_tvalid_i && buf_ready;
  assign s_axis_tready_o = buf_ready;
  assign opcode          = opcode_e'(s_axis_tuser_i);

  // Decode one accepted transfer into the cell controls and the head state.
  always_comb begin
    ctrl  = '0;
    emit  = 1'b0;
    len_d = len_q;
    ovf_d = ovf_q;
    a0_d  = a0_q;
    if (accept) begin
      unique case (opcode)
        OP_CLEAR: begin
          len_d        = '0;
          ovf_d        = 1'b0;
          ctrl.restart = 1'b1;
          a0_d         = 1'b1;
        end
        OP_APPEND: begin
          if (len_q < LEN_W'(MAX_PATTERN)) begin
            ctrl.load = 1'b1;
            len_d     = len_q + LEN_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          ctrl.restart = 1'b1;
          a0_d         = 1'b1;
        end
        OP_TEXT: begin
          ctrl.consume = 1'b1;
          a0_d         = 1'b0;
        end
        OP_END: begin
          emit         = 1'b1;
          ctrl.restart = 1'b1;
          a0_d         = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
      a0_q  <= 1'b1;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      a0_q  <= a0_d;
    end
  end

  // The empty prefix is never advanced past; it heads the closure chain.
  assign closed[0] = a0_q;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wgm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .char_i        (s_axis_tdata_i),
      .len_i         (len_q),
      .closed_prev_i (closed[i]),
      .closed_o      (closed[i+1]),
      .match_o       (match_vec[i])
    );
  end

  // The prefix of full pattern length decides the match.
  assign res.matched  = (a0_q && (len_q == '0)) || (|match_vec);
  assign res.overflow = ovf_q;

  wgm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {6'b0, out_res.overflow, out_res.matched};

endmodule

// File: design/wgm_checker.sv
// Port-level checker for the wildcard glob matcher, bound to the top level.
// Depends on wgm_pkg and wildcard_glob_matcher_unit.
`timescale 1ns / 1ps

module wgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic [1:0] s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);
  import wgm_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Every end-of-text transfer leaves a result on offer in the next cycle.
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i == OP_END) |=> m_axis_tvalid_o)
    else $error("end of text produced no result");

  // Other opcodes never create a result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i != OP_END) && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result without end of text");

  // Empty pattern right after a clear matches the empty text, no overflow.
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i == OP_END) && !m_axis_tvalid_o &&
    $past(s_acc && (s_axis_tuser_i == OP_CLEAR))
    |=> m_axis_tdata_o[1:0] == 2'b01)
    else $error("empty pattern did not match empty text");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:2] == 6'b0)
    else $error("result padding not zero");

  logic unused_data;
  assign unused_data = ^s_axis_tdata_i;

endmodule

bind wildcard_glob_matcher_unit wgm_checker u_wgm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
